### rtl/core/pfb_pkg.sv
// Shared types, codes and defaults of the page framebuffer draw engine.
`default_nettype none
package pfb_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int ROWS_DEF    = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_VLINE = 3'd1,
    CMD_BOX   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START_X = 3'd0,
    CFG_WIN_START_Y = 3'd1,
    CFG_WIN_W       = 3'd2,
    CFG_WIN_H       = 3'd3,
    CFG_DRAW_MODE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OR   = 2'd0,
    MODE_CLR  = 2'd1,
    MODE_XOR  = 2'd2,
    MODE_KEEP = 2'd3
  } mode_e;

  typedef struct packed {
    logic load;
    logic rej_set;
    logic box_init;
    logic box_step;
    logic line_load;
    logic line_step;
    logic put_calc;
    logic rd_a;
    logic wr_a;
    logic rd_b;
    logic wr_b;
    logic rd_issue;
    logic rd_capture;
    logic clr_wr;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic box_bad;
    logic box_empty;
    logic box_last;
    logic line_rej;
    logic line_empty;
    logic rem_more;
    logic put_bad;
    logic read_ok;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/pfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/pfb_ctrl.sv
// Command sequencer of the page framebuffer draw engine.
`default_nettype none
module pfb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pfb_pkg::sts_t sts_i,
  output pfb_pkg::ctl_t      ctl_o
);
  import pfb_pkg::*;

  typedef enum logic [14:0] {
    S_INIT     = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_DECODE   = 15'b000000000000100,
    S_LINE_SET = 15'b000000000001000,
    S_PUT_SET  = 15'b000000000010000,
    S_RD_A     = 15'b000000000100000,
    S_WR_A     = 15'b000000001000000,
    S_RD_B     = 15'b000000010000000,
    S_WR_B     = 15'b000000100000000,
    S_LINE_NXT = 15'b000001000000000,
    S_BOX_NXT  = 15'b000010000000000,
    S_CLR      = 15'b000100000000000,
    S_RD_RAM   = 15'b001000000000000,
    S_RD_DATA  = 15'b010000000000000,
    S_RESP     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_INIT: begin
        ctl_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cmd)
          CMD_WRITE: state_d = S_PUT_SET;
          CMD_VLINE: state_d = S_LINE_SET;
          CMD_BOX: begin
            if (sts_i.box_bad) begin
              ctl_o.rej_set = 1'b1;
              state_d       = S_RESP;
            end else if (sts_i.box_empty) begin
              state_d = S_RESP;
            end else begin
              ctl_o.box_init = 1'b1;
              state_d        = S_LINE_SET;
            end
          end
          CMD_CLEAR: state_d = S_CLR;
          CMD_READ: begin
            if (sts_i.read_ok) begin
              state_d = S_RD_RAM;
            end else begin
              ctl_o.rej_set = 1'b1;
              state_d       = S_RESP;
            end
          end
          default: begin
            ctl_o.rej_set = 1'b1;
            state_d       = S_RESP;
          end
        endcase
      end
      S_LINE_SET: begin
        if (sts_i.line_rej || sts_i.line_empty) begin
          ctl_o.rej_set = sts_i.line_rej && (sts_i.cmd == CMD_VLINE);
          state_d       = (sts_i.cmd == CMD_BOX) ? S_BOX_NXT : S_RESP;
        end else begin
          ctl_o.line_load = 1'b1;
          state_d         = S_PUT_SET;
        end
      end
      S_PUT_SET: begin
        if (sts_i.put_bad) begin
          ctl_o.rej_set = (sts_i.cmd == CMD_WRITE);
          state_d       = (sts_i.cmd == CMD_WRITE) ? S_RESP : S_LINE_NXT;
        end else begin
          ctl_o.put_calc = 1'b1;
          state_d        = S_RD_A;
        end
      end
      S_RD_A: begin
        ctl_o.rd_a = 1'b1;
        state_d    = S_WR_A;
      end
      S_WR_A: begin
        ctl_o.wr_a = 1'b1;
        state_d    = S_RD_B;
      end
      S_RD_B: begin
        ctl_o.rd_b = 1'b1;
        state_d    = S_WR_B;
      end
      S_WR_B: begin
        ctl_o.wr_b = 1'b1;
        state_d    = (sts_i.cmd == CMD_WRITE) ? S_RESP : S_LINE_NXT;
      end
      S_LINE_NXT: begin
        if (sts_i.rem_more) begin
          ctl_o.line_step = 1'b1;
          state_d         = S_PUT_SET;
        end else begin
          state_d = (sts_i.cmd == CMD_BOX) ? S_BOX_NXT : S_RESP;
        end
      end
      S_BOX_NXT: begin
        if (sts_i.box_last) begin
          state_d = S_RESP;
        end else begin
          ctl_o.box_step = 1'b1;
          state_d        = S_LINE_SET;
        end
      end
      S_CLR: begin
        ctl_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_RESP;
        end
      end
      S_RD_RAM: begin
        ctl_o.rd_issue = 1'b1;
        state_d        = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pfb_datapath.sv
// Datapath of the page framebuffer draw engine: registers, address math and store.
`default_nettype none
module pfb_datapath #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
  parameter int ROWS    = pfb_pkg::ROWS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pfb_pkg::ctl_t                    ctl_i,
  output pfb_pkg::sts_t                         sts_o,
  input  wire logic [2:0]                       command_i,
  input  wire logic signed [9:0]                pos_x_i,
  input  wire logic signed [9:0]                pos_y_i,
  input  wire logic signed [9:0]                line_end_i,
  input  wire logic [7:0]                       box_width_i,
  input  wire logic [7:0]                       box_height_i,
  input  wire logic [6:0]                       corner_i,
  input  wire logic [7:0]                       pattern_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pfb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [7:0]                            read_data_o,
  output logic                                  rejected_o
);
  import pfb_pkg::*;

  localparam int PAGES = ROWS / 8;
  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [11:0] COLS_S  = 12'(COLUMNS);
  localparam logic signed [11:0] PAGES_S = 12'(PAGES);

  logic [6:0] wsx_q, ww_q;
  logic [5:0] wsy_q, wh_q;
  mode_e      mode_q;

  logic [2:0]        command_q;
  logic signed [9:0] px_q, py_q, pe_q;
  logic [7:0]        bw_q, bh_q, pat_q;
  logic [6:0]        cr_q;

  logic [7:0]         box_i_q, box_r_q;
  logic signed [11:0] lx_q, ly_q;
  logic [5:0]         rem_q;
  logic [AW-1:0]      addr_a_q, addr_b_q, clr_q;
  logic [7:0]         bits_a_q, bits_b_q;
  logic               en_a_q, en_b_q;
  logic               rej_q;
  logic [7:0]         rdata_q;
  logic               out_valid_q;
  logic [7:0]         out_data_q;
  logic               out_rej_q;

  logic signed [11:0] px_e, py_e, pe_e, ww_e, wh_e;
  logic signed [11:0] src_x, src_t, src_e, top_c, end_c, dlen;
  logic signed [11:0] put_x, put_y, col, row, page, page_b;
  logic [2:0]         sh;
  logic [7:0]         mask_val, put_val, bits_a, bits_b;
  logic               is_wr, is_box, col_ok;
  logic [AW-1:0]      addr_a, addr_b, rd_addr;
  logic               box_dec, box_inc;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata, old_bits;

  assign cfg_ready_o = 1'b1;

  assign is_wr  = (command_q == CMD_WRITE);
  assign is_box = (command_q == CMD_BOX);
  assign px_e   = {{2{px_q[9]}}, px_q};
  assign py_e   = {{2{py_q[9]}}, py_q};
  assign pe_e   = {{2{pe_q[9]}}, pe_q};
  assign ww_e   = $signed({5'b0, ww_q});
  assign wh_e   = $signed({6'b0, wh_q});

  always_comb begin
    if (is_box) begin
      src_x = px_e + $signed({4'b0, box_i_q});
      src_t = py_e + $signed({4'b0, box_r_q});
      src_e = py_e + $signed({4'b0, bh_q}) - $signed({4'b0, box_r_q});
    end else begin
      src_x = px_e;
      src_t = py_e;
      src_e = pe_e;
    end
    top_c = (src_t < 12'sd0) ? 12'sd0 : src_t;
    end_c = (src_e > wh_e) ? wh_e : src_e;
    dlen  = end_c - top_c;
  end

  always_comb begin
    put_x    = is_wr ? px_e : lx_q;
    put_y    = is_wr ? py_e : ly_q;
    mask_val = (rem_q >= 6'd8) ? 8'hFF : ((8'd1 << rem_q[2:0]) - 8'd1);
    put_val  = is_wr ? pat_q : mask_val;
    col      = $signed({5'b0, wsx_q}) + put_x;
    row      = $signed({6'b0, wsy_q}) + put_y;
    page     = row >>> 3;
    page_b   = page + 12'sd1;
    sh       = row[2:0];
    bits_a   = put_val << sh;
    bits_b   = put_val >> (4'd8 - {1'b0, sh});
    col_ok   = (col >= 12'sd0) && (col < COLS_S);
    addr_a   = AW'(int'(page) * COLUMNS + int'(col));
    addr_b   = AW'(int'(page_b) * COLUMNS + int'(col));
    rd_addr  = AW'(int'(py_e) * COLUMNS + int'(px_e));
    box_dec  = ({1'b0, box_i_q} < {2'b0, cr_q});
    box_inc  = (({1'b0, box_i_q} + {2'b0, cr_q} + 9'd1) >= {1'b0, bw_q});
  end

  always_comb begin
    sts_o            = '0;
    sts_o.cmd        = cmd_e'(command_q);
    sts_o.box_bad    = ({1'b0, cr_q, 1'b0} > {1'b0, bw_q}) ||
                       ({1'b0, cr_q, 1'b0} > {1'b0, bh_q});
    sts_o.box_empty  = (bw_q == 8'd0);
    sts_o.box_last   = (box_i_q == bw_q - 8'd1);
    sts_o.line_rej   = ((src_t < 12'sd0) && (src_e < 12'sd0)) ||
                       (src_x < 12'sd0) || (src_x > ww_e);
    sts_o.line_empty = (dlen <= 12'sd0);
    sts_o.rem_more   = (rem_q > 6'd8);
    sts_o.put_bad    = (put_x < 12'sd0) || (put_x > ww_e) || (put_y > wh_e) ||
                       (put_y < -12'sd6);
    sts_o.read_ok    = (px_e >= 12'sd0) && (px_e < COLS_S) &&
                       (py_e >= 12'sd0) && (py_e < PAGES_S);
    sts_o.clr_last   = (clr_q == AW'(DEPTH - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    old_bits  = ctl_i.wr_a ? bits_a_q : bits_b_q;
    ram_we    = ctl_i.clr_wr || (ctl_i.wr_a && en_a_q) || (ctl_i.wr_b && en_b_q);
    ram_waddr = ctl_i.clr_wr ? clr_q : (ctl_i.wr_a ? addr_a_q : addr_b_q);
    case (mode_q)
      MODE_OR:  ram_wdata = ram_rdata | old_bits;
      MODE_CLR: ram_wdata = ram_rdata & ~old_bits;
      MODE_XOR: ram_wdata = ram_rdata ^ old_bits;
      default:  ram_wdata = ram_rdata;
    endcase
    if (ctl_i.clr_wr) begin
      ram_wdata = 8'h00;
    end
    ram_re    = ctl_i.rd_a || ctl_i.rd_b || ctl_i.rd_issue;
    ram_raddr = ctl_i.rd_a ? addr_a_q : (ctl_i.rd_b ? addr_b_q : rd_addr);
  end

  pfb_ram #(
    .Width(8),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsx_q  <= 7'd0;
      wsy_q  <= 6'd0;
      ww_q   <= 7'd127;
      wh_q   <= 6'd63;
      mode_q <= MODE_OR;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIN_START_X: wsx_q  <= cfg_data_i[6:0];
        CFG_WIN_START_Y: wsy_q  <= cfg_data_i[5:0];
        CFG_WIN_W:       ww_q   <= cfg_data_i[6:0];
        CFG_WIN_H:       wh_q   <= cfg_data_i[5:0];
        CFG_DRAW_MODE:   mode_q <= mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr_wr) begin
        clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + AW'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      command_q <= command_i;
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      pe_q      <= line_end_i;
      bw_q      <= box_width_i;
      bh_q      <= box_height_i;
      cr_q      <= corner_i;
      pat_q     <= pattern_i;
      rej_q     <= 1'b0;
      rdata_q   <= 8'h00;
    end
    if (ctl_i.rej_set) begin
      rej_q <= 1'b1;
    end
    if (ctl_i.rd_capture) begin
      rdata_q <= ram_rdata;
    end
    if (ctl_i.box_init) begin
      box_i_q <= 8'd0;
      box_r_q <= {1'b0, cr_q};
    end
    if (ctl_i.box_step) begin
      box_i_q <= box_i_q + 8'd1;
      box_r_q <= box_r_q - {7'd0, box_dec} + {7'd0, box_inc};
    end
    if (ctl_i.line_load) begin
      lx_q  <= src_x;
      ly_q  <= top_c;
      rem_q <= dlen[5:0];
    end
    if (ctl_i.line_step) begin
      ly_q  <= ly_q + 12'sd8;
      rem_q <= rem_q - 6'd8;
    end
    if (ctl_i.put_calc) begin
      addr_a_q <= addr_a;
      addr_b_q <= addr_b;
      bits_a_q <= bits_a;
      bits_b_q <= bits_b;
      en_a_q   <= col_ok && (page >= 12'sd0) && (page < PAGES_S);
      en_b_q   <= col_ok && (sh != 3'd0) && (page_b >= 12'sd0) && (page_b < PAGES_S);
    end
    if (ctl_i.out_load) begin
      out_data_q <= rdata_q;
      out_rej_q  <= rej_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign rejected_o  = out_rej_q;

endmodule
`default_nettype wire

### rtl/core/page_framebuffer_draw_engine.sv
// Top level of the page framebuffer draw engine.
// The block keeps a monochrome store of ROWS/8 pages by COLUMNS column bytes.
// Commands arrive on the input channel (in_valid_i/in_ready_o), one word each,
// and each gives exactly one result word on the output channel
// (out_valid_o/out_ready_i) with read_data_o and rejected_o.
// Window and draw mode registers are written through the cfg channel, which is
// always ready; write them only while no command is in flight.
// One command is worked at a time. A byte write is a read-modify-write of up to
// two store bytes, each read waiting on the registered read port of the store.
// A vertical line is written one 8-row segment at a time, a box as one vertical
// line per column, and a clear zeroes every store byte (PAGES*COLUMNS), one per
// cycle. After reset the store is swept to zero, one byte per cycle (PAGES*COLUMNS
// bytes, 1024 by default), before the first command is taken.
// The result sits in an output register; a stalled receiver holds it there and
// the block takes the next command meanwhile, finishing it when the register frees.
`default_nettype none
module page_framebuffer_draw_engine #(
  parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
  parameter int ROWS    = pfb_pkg::ROWS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [2:0]                     command_i,
  input  wire logic signed [9:0]              pos_x_i,
  input  wire logic signed [9:0]              pos_y_i,
  input  wire logic signed [9:0]              line_end_i,
  input  wire logic [7:0]                     box_width_i,
  input  wire logic [7:0]                     box_height_i,
  input  wire logic [6:0]                     corner_i,
  input  wire logic [7:0]                     pattern_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          read_data_o,
  output logic                                rejected_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pfb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  pfb_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .command_i   (command_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .line_end_i  (line_end_i),
    .box_width_i (box_width_i),
    .box_height_i(box_height_i),
    .corner_i    (corner_i),
    .pattern_i   (pattern_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .rejected_o  (rejected_o)
  );

endmodule
`default_nettype wire

### rtl/core/pfb_checker.sv
// Port-level checks of the page framebuffer draw engine and their binding.
`default_nettype none
module pfb_port_checks (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_o,
  input wire logic       rejected_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(rejected_o))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  a_data_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != 8'h00) |-> !rejected_o)
    else $error("rejected result carries data");

  a_no_result_while_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without work");

endmodule

bind page_framebuffer_draw_engine pfb_port_checks u_pfb_port_checks (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .read_data_o(read_data_o),
  .rejected_o (rejected_o)
);
`default_nettype wire

### dv/pfb_checker.sv
// Checker that predicts and compares the results of the page framebuffer draw engine.
module pfb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        command_i,
  input  logic signed [9:0] pos_x_i,
  input  logic signed [9:0] pos_y_i,
  input  logic signed [9:0] line_end_i,
  input  logic [7:0]        box_width_i,
  input  logic [7:0]        box_height_i,
  input  logic [6:0]        corner_i,
  input  logic [7:0]        pattern_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        read_data_i,
  input  logic              rejected_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import pfb_pkg::*;

  localparam int NCOL  = 128;
  localparam int NPAGE = 8;

  typedef struct {
    logic [7:0] data;
    logic       rej;
  } draw_result_t;

  logic [7:0]   frame[NPAGE*NCOL];
  logic [6:0]   org_x;
  logic [5:0]   org_y;
  logic [6:0]   lim_x;
  logic [5:0]   lim_y;
  mode_e        mode;
  draw_result_t result_q[$];

  assign pending_o = result_q.size();

  function automatic void merge_byte(int col, int page, logic [7:0] bits);
    if (col < 0 || col >= NCOL || page < 0 || page >= NPAGE) return;
    case (mode)
      MODE_OR:  frame[page*NCOL+col] = frame[page*NCOL+col] | bits;
      MODE_CLR: frame[page*NCOL+col] = frame[page*NCOL+col] & ~bits;
      MODE_XOR: frame[page*NCOL+col] = frame[page*NCOL+col] ^ bits;
      default: ;
    endcase
  endfunction

  function automatic bit put_byte(int x, int y, logic [7:0] val);
    int row, col, page, sh;
    logic [15:0] wide;
    if (x < 0 || x > int'(lim_x) || y > int'(lim_y) || y <= -7) return 0;
    col  = int'(org_x) + x;
    row  = int'(org_y) + y;
    page = (row >= 0) ? row / 8 : -((-row + 7) / 8);
    sh   = row - page * 8;
    wide = {8'h00, val} << sh;
    merge_byte(col, page, wide[7:0]);
    if (sh != 0) merge_byte(col, page + 1, wide[15:8]);
    return 1;
  endfunction

  function automatic bit draw_vline(int x, int top, int bottom);
    int d, full, rest;
    if (top < 0 && bottom < 0) return 0;
    if (top < 0) top = 0;
    if (bottom > int'(lim_y)) bottom = int'(lim_y);
    if (x < 0 || x > int'(lim_x)) return 0;
    d = bottom - top;
    if (d <= 0) return 1;
    full = d / 8;
    rest = d % 8;
    for (int i = 0; i < full; i++) void'(put_byte(x, top + i * 8, 8'hFF));
    if (rest != 0) void'(put_byte(x, top + full * 8, 8'((1 << rest) - 1)));
    return 1;
  endfunction

  function automatic bit draw_box(int x0, int y0, int w, int h, int rad);
    int r;
    r = rad;
    if (2 * rad > w || 2 * rad > h) return 0;
    for (int i = 0; i < w; i++) begin
      void'(draw_vline(x0 + i, y0 + r, y0 + h - r));
      if (i < rad) r--;
      if (i >= w - rad - 1) r++;
    end
    return 1;
  endfunction

  function automatic draw_result_t run_command();
    draw_result_t res;
    int px, py;
    res.data = 8'h00;
    res.rej  = 1'b0;
    px = int'(pos_x_i);
    py = int'(pos_y_i);
    case (command_i)
      CMD_WRITE: res.rej = !put_byte(px, py, pattern_i);
      CMD_VLINE: res.rej = !draw_vline(px, py, int'(line_end_i));
      CMD_BOX:   res.rej = !draw_box(px, py, int'(box_width_i), int'(box_height_i),
                                     int'(corner_i));
      CMD_CLEAR: foreach (frame[i]) frame[i] = 8'h00;
      CMD_READ: begin
        if (px >= 0 && px < NCOL && py >= 0 && py < NPAGE) res.data = frame[py*NCOL+px];
        else res.rej = 1'b1;
      end
      default: res.rej = 1'b1;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_result_t got, exp_res;
    if (!rst_ni) begin
      foreach (frame[i]) frame[i] = 8'h00;
      org_x = 0;
      org_y = 0;
      lim_x = 7'd127;
      lim_y = 6'd63;
      mode = MODE_OR;
      result_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIN_START_X: org_x = cfg_data_i;
          CFG_WIN_START_Y: org_y = cfg_data_i[5:0];
          CFG_WIN_W:       lim_x = cfg_data_i;
          CFG_WIN_H:       lim_y = cfg_data_i[5:0];
          CFG_DRAW_MODE:   mode = mode_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.data = read_data_i;
        got.rej  = rejected_i;
        if (result_q.size() == 0) begin
          $error("unexpected result word: read_data %0h rejected %0b", got.data, got.rej);
          fail_count_o++;
        end else begin
          exp_res = result_q.pop_front();
          if (got.data !== exp_res.data) begin
            $error("read_data: expected %0h actual %0h", exp_res.data, got.data);
            fail_count_o++;
          end
          if (got.rej !== exp_res.rej) begin
            $error("rejected: expected %0b actual %0b", exp_res.rej, got.rej);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) result_q.push_back(run_command());
    end
  end
endmodule

### dv/tb_top.sv
// Testbench top that drives commands and configuration into the draw engine.
module tb_top;
  import pfb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM    = 1300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        command_i = '0;
  logic signed [9:0] pos_x_i = '0;
  logic signed [9:0] pos_y_i = '0;
  logic signed [9:0] line_end_i = '0;
  logic [7:0]        box_width_i = '0;
  logic [7:0]        box_height_i = '0;
  logic [6:0]        corner_i = '0;
  logic [7:0]        pattern_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        read_data_o;
  logic              rejected_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [6:0]        cfg_data_i = '0;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  bit                hold_request = 0;
  int                burst_left = 0;
  int                lim_x = 127;
  int                lim_y = 63;

  page_framebuffer_draw_engine uut (.*);

  pfb_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .pos_x_i,
    .pos_y_i, .line_end_i, .box_width_i, .box_height_i, .corner_i, .pattern_i,
    .out_valid_i(out_valid_o), .out_ready_i, .read_data_i(read_data_o),
    .rejected_i(rejected_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL page_framebuffer_draw_engine");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left, style, style_left;
    hold_left = 0;
    style = 0;
    style_left = 0;
    forever begin
      @(posedge clk_i);
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 300);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = 3000;
        out_ready_i <= 1'b0;
      end else begin
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_word(logic [2:0] cmd, int px, int py, int pe, int bw, int bh,
                           int cr, int pat);
    int gap;
    if (burst_left == 0) begin
      burst_left = pick(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : pick(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    pos_x_i      <= 10'(px);
    pos_y_i      <= 10'(py);
    line_end_i   <= 10'(pe);
    box_width_i  <= 8'(bw);
    box_height_i <= 8'(bh);
    corner_i     <= 7'(cr);
    pattern_i    <= 8'(pat);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup_window(int sx, int sy, int w, int h, mode_e m);
    drain();
    write_reg(CFG_WIN_START_X, sx);
    write_reg(CFG_WIN_START_Y, sy);
    write_reg(CFG_WIN_W, w);
    write_reg(CFG_WIN_H, h);
    write_reg(CFG_DRAW_MODE, m);
    lim_x = w;
    lim_y = h;
  endtask

  task automatic random_word();
    int sel, bw, bh;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      send_word(CMD_WRITE, pick(-3, lim_x + 3), pick(-9, lim_y + 3), 0, 0, 0, 0,
                $urandom_range(0, 255));
    end else if (sel < 48) begin
      send_word(CMD_VLINE, pick(-3, lim_x + 3), pick(-12, lim_y + 4),
                pick(-12, lim_y + 12), $urandom_range(0, 255), 0, 0, 0);
    end else if (sel < 60) begin
      bw = pick(0, 16);
      bh = pick(0, 24);
      send_word(CMD_BOX, pick(-8, lim_x), pick(-10, lim_y), 0, bw, bh,
                pick(0, 5), 0);
    end else if (sel < 61) begin
      send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    end else if (sel < 92) begin
      send_word(CMD_READ, pick(-2, 129), pick(-1, 8), 0, 0, 0, 0, 0);
    end else if (sel < 94) begin
      send_word(3'(pick(5, 7)), pick(-512, 511), pick(-512, 511), 0, 0, 0, 0, 0);
    end else begin
      send_word(3'($urandom_range(0, 4)), pick(-512, 511), pick(-512, 511),
                pick(-512, 511), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 127), $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wait (in_ready_o);
    setup_window(0, 0, 127, 63, MODE_OR);

    send_word(CMD_WRITE, 0, 0, 0, 0, 0, 0, 8'hFF);
    send_word(CMD_WRITE, 127, 63, 0, 0, 0, 0, 8'hA5);
    send_word(CMD_WRITE, 5, 3, 0, 0, 0, 0, 8'hFF);
    send_word(CMD_WRITE, 6, -6, 0, 0, 0, 0, 8'hFF);
    send_word(CMD_WRITE, 6, -7, 0, 0, 0, 0, 8'hFF);
    send_word(CMD_WRITE, -1, 0, 0, 0, 0, 0, 8'hFF);
    send_word(CMD_WRITE, 128, 64, 0, 0, 0, 0, 8'h00);
    send_word(CMD_VLINE, 10, -5, -1, 0, 0, 0, 0);
    send_word(CMD_VLINE, 10, -5, 20, 0, 0, 0, 0);
    send_word(CMD_VLINE, 11, 3, 500, 0, 0, 0, 0);
    send_word(CMD_VLINE, 12, 9, 9, 0, 0, 0, 0);
    send_word(CMD_VLINE, 12, 20, 4, 0, 0, 0, 0);
    send_word(CMD_BOX, 20, 4, 0, 12, 14, 3, 0);
    send_word(CMD_BOX, 40, 4, 0, 4, 30, 3, 0);
    send_word(CMD_BOX, 40, 4, 0, 0, 0, 0, 0);
    send_word(CMD_BOX, -512, -512, 0, 255, 255, 127, 0);
    send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 5, 0, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 127, 7, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 128, 0, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 0, -1, 0, 0, 0, 0, 0);
    send_word(3'd7, 511, 511, 511, 255, 255, 127, 255);
    send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_READ, 0, 0, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: setup_window(0, 0, 127, 63, MODE_OR);
        1: setup_window(127, 63, 0, 0, MODE_CLR);
        2: setup_window(pick(0, 20), pick(0, 20), pick(60, 127), pick(30, 63), MODE_XOR);
        3: setup_window(pick(0, 127), pick(0, 63), pick(0, 127), pick(0, 63), MODE_KEEP);
        4: setup_window(pick(0, 8), pick(0, 12), pick(90, 127), pick(40, 63), MODE_OR);
        default: setup_window(pick(0, 40), pick(0, 30), pick(0, 127), pick(0, 63),
                              MODE_XOR);
      endcase
      if (phase == 2) hold_request = 1;
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if (phase == 3 && n == 100) drain();
        if (n % 90 == 45) send_word(CMD_BOX, pick(-4, 10), pick(-4, 10), 0, 255,
                                    pick(0, 255), pick(0, 5), 0);
        else random_word();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS page_framebuffer_draw_engine");
    end else begin
      $display("FAIL page_framebuffer_draw_engine");
    end
    $finish;
  end
endmodule

### page_framebuffer_draw_engine.f
rtl/core/pfb_pkg.sv
rtl/core/pfb_ram.sv
rtl/core/pfb_ctrl.sv
rtl/core/pfb_datapath.sv
rtl/core/page_framebuffer_draw_engine.sv
rtl/core/pfb_checker.sv
dv/pfb_checker.sv
dv/tb_top.sv
